/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;
  localparam int MAX_RESULTS  = 16;

  localparam int PRIO_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int OUT_ID_W   = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [PRIO_W-1:0] MIN_PRIO_RST = 4'd1;
  localparam logic [PRIO_W-1:0] MAX_PRIO_RST = 4'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED    = 3'd0,
    STS_REMOVED  = 3'd1,
    STS_LISTED   = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_BAD_PRIO = 3'd4,
    STS_FULL     = 3'd5,
    STS_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PRIO = 1'd0,
    REG_MAX_PRIO = 1'd1
  } cfg_reg_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PRIO_W-1:0] new_prio;
  } cell_ctl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an identifier and a priority and moves
// them to or from its neighbors on insert, pop and rotate.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int ID_BITS = spq_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  spq_pkg::cell_ctl_t        ctl_i,
  input  logic                      occupied_i,
  input  logic                      tail_i,
  input  logic                      left_gt_i,
  input  logic [ID_BITS-1:0]        left_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio_i,
  input  logic [ID_BITS-1:0]        right_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio_i,
  input  logic [ID_BITS-1:0]        head_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] head_prio_i,
  input  logic [ID_BITS-1:0]        new_id_i,
  output logic                      gt_o,
  output logic [ID_BITS-1:0]        id_o,
  output logic [spq_pkg::PRIO_W-1:0] prio_o
);

  logic [ID_BITS-1:0]         id_r;
  logic [ID_BITS-1:0]         id_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_r;
  logic [spq_pkg::PRIO_W-1:0] prio_nxt;

  // An occupied cell with a strictly higher priority stays ahead of a new entry.
  assign gt_o   = occupied_i && (prio_r > ctl_i.new_prio);
  assign id_o   = id_r;
  assign prio_o = prio_r;

  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    unique case (ctl_i.op)
      spq_pkg::OP_HOLD: begin
      end
      spq_pkg::OP_INSERT: begin
        if (!gt_o) begin
          if (left_gt_i) begin
            id_nxt   = new_id_i;
            prio_nxt = ctl_i.new_prio;
          end else begin
            id_nxt   = left_id_i;
            prio_nxt = left_prio_i;
          end
        end
      end
      spq_pkg::OP_SHIFT: begin
        id_nxt   = right_id_i;
        prio_nxt = right_prio_i;
      end
      spq_pkg::OP_ROTATE: begin
        if (tail_i) begin
          id_nxt   = head_id_i;
          prio_nxt = head_prio_i;
        end else begin
          id_nxt   = right_id_i;
          prio_nxt = right_prio_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Bounded priority queue kept sorted by descending priority in a chain of
// CAPACITY cells, newest first among equal priorities. Add, remove and clear
// need no walk of the chain, so they can be accepted on every cycle while
// the result register drains. A display request on a non-empty queue walks
// the chain by rotating it one cell per cycle while the result register is
// free, once round all entries, and the input stays stalled for the whole
// walk and whenever the result register is held by a stalled consumer.
// Every request yields its results through one registered output stage.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted priority queue with add, remove head, display and clear commands.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = spq_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spq_pkg::CMD_W-1:0]      in_cmd,
  input  logic [spq_pkg::PRIO_W-1:0]     in_priority_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spq_pkg::STATUS_W-1:0]   out_status,
  output logic [spq_pkg::OUT_ID_W-1:0]   out_entry_id,
  output logic [spq_pkg::PRIO_W-1:0]     out_entry_priority,
  output logic                           out_last
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  spq_pkg::fsm_t              state_r;
  spq_pkg::fsm_t              state_nxt;
  logic [OCC_W-1:0]           occ_r;
  logic [OCC_W-1:0]           occ_nxt;
  logic [OCC_W-1:0]           idx_r;
  logic [OCC_W-1:0]           idx_nxt;
  logic [ID_BITS-1:0]         next_id_r;
  logic [ID_BITS-1:0]         next_id_nxt;
  logic [spq_pkg::PRIO_W-1:0] min_prio_r;
  logic [spq_pkg::PRIO_W-1:0] max_prio_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [spq_pkg::STATUS_W-1:0] out_status_r;
  logic [spq_pkg::STATUS_W-1:0] out_status_nxt;
  logic [ID_BITS-1:0]           out_id_r;
  logic [ID_BITS-1:0]           out_id_nxt;
  logic [spq_pkg::PRIO_W-1:0]   out_prio_r;
  logic [spq_pkg::PRIO_W-1:0]   out_prio_nxt;
  logic                         out_last_r;
  logic                         out_last_nxt;

  logic               accept;
  logic               out_free;
  logic               prio_ok;
  logic               is_full;
  logic               is_empty;
  logic               list_end;
  spq_pkg::cmd_t      cmd;
  spq_pkg::cell_ctl_t ctl;

  logic [ID_BITS-1:0]         id_w   [CAPACITY];
  logic [spq_pkg::PRIO_W-1:0] prio_w [CAPACITY];
  logic                       gt_w   [CAPACITY];
  logic [ID_BITS+spq_pkg::OUT_ID_W-1:0] id_ext;

  assign cmd      = spq_pkg::cmd_t'(in_cmd);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != spq_pkg::FSM_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign prio_ok  = (in_priority_req >= min_prio_r) && (in_priority_req <= max_prio_r);
  assign is_full  = (occ_r == OCC_W'(CAPACITY));
  assign is_empty = (occ_r == '0);
  assign list_end = (idx_r == occ_r - OCC_W'(1));

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
      localparam int RIGHT = (gi == CAPACITY - 1) ? gi : gi + 1;
      spq_cell #(
        .ID_BITS(ID_BITS)
      ) u_cell (
        .clk         (clk),
        .ctl_i       (ctl),
        .occupied_i  (OCC_W'(gi) < occ_r),
        .tail_i      (occ_r == OCC_W'(gi + 1)),
        .left_gt_i   ((gi == 0) ? 1'b1 : gt_w[LEFT]),
        .left_id_i   (id_w[LEFT]),
        .left_prio_i (prio_w[LEFT]),
        .right_id_i  (id_w[RIGHT]),
        .right_prio_i(prio_w[RIGHT]),
        .head_id_i   (id_w[0]),
        .head_prio_i (prio_w[0]),
        .new_id_i    (next_id_r),
        .gt_o        (gt_w[gi]),
        .id_o        (id_w[gi]),
        .prio_o      (prio_w[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::FSM_IDLE: begin
        if (accept && (cmd == spq_pkg::CMD_DISPLAY) && !is_empty) begin
          state_nxt = spq_pkg::FSM_LIST;
        end
      end
      spq_pkg::FSM_LIST: begin
        if (out_free && list_end) begin
          state_nxt = spq_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = spq_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    ctl.op         = spq_pkg::OP_HOLD;
    ctl.new_prio   = in_priority_req;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    next_id_nxt    = next_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      spq_pkg::FSM_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_prio_nxt  = '0;
          out_last_nxt  = 1'b1;
          unique case (cmd)
            spq_pkg::CMD_ADD: begin
              out_prio_nxt = in_priority_req;
              if (!prio_ok) begin
                out_status_nxt = spq_pkg::STS_BAD_PRIO;
              end else if (is_full) begin
                out_status_nxt = spq_pkg::STS_FULL;
              end else begin
                ctl.op         = spq_pkg::OP_INSERT;
                out_status_nxt = spq_pkg::STS_ADDED;
                out_id_nxt     = next_id_r;
                occ_nxt        = occ_r + OCC_W'(1);
                next_id_nxt    = next_id_r + ID_BITS'(1);
              end
            end
            spq_pkg::CMD_REMOVE: begin
              if (is_empty) begin
                out_status_nxt = spq_pkg::STS_EMPTY;
              end else begin
                ctl.op         = spq_pkg::OP_SHIFT;
                out_status_nxt = spq_pkg::STS_REMOVED;
                out_id_nxt     = id_w[0];
                out_prio_nxt   = prio_w[0];
                occ_nxt        = occ_r - OCC_W'(1);
              end
            end
            spq_pkg::CMD_DISPLAY: begin
              out_status_nxt = spq_pkg::STS_EMPTY;
              if (!is_empty) begin
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
              end
            end
            spq_pkg::CMD_CLEAR: begin
              out_status_nxt = spq_pkg::STS_CLEARED;
              occ_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end
      spq_pkg::FSM_LIST: begin
        if (out_free) begin
          ctl.op  = spq_pkg::OP_ROTATE;
          idx_nxt = idx_r + OCC_W'(1);
          if (32'(idx_r) < spq_pkg::MAX_RESULTS) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = spq_pkg::STS_LISTED;
            out_id_nxt     = id_w[0];
            out_prio_nxt   = prio_w[0];
            out_last_nxt   = list_end || (32'(idx_r) == spq_pkg::MAX_RESULTS - 1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::FSM_IDLE;
      occ_r       <= '0;
      idx_r       <= '0;
      next_id_r   <= ID_BITS'(1);
      min_prio_r  <= spq_pkg::MIN_PRIO_RST;
      max_prio_r  <= spq_pkg::MAX_PRIO_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (spq_pkg::cfg_reg_t'(cfg_index))
          spq_pkg::REG_MIN_PRIO: min_prio_r <= cfg_wdata;
          spq_pkg::REG_MAX_PRIO: max_prio_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign id_ext             = {{spq_pkg::OUT_ID_W{1'b0}}, out_id_r};
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_id       = id_ext[spq_pkg::OUT_ID_W-1:0];
  assign out_entry_priority = out_prio_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= CAPACITY)
    else $error("Occupancy exceeds the capacity.");

  a_list_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::FSM_LIST) |-> in_stall)
    else $error("Input accepted while the queue is being listed.");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd == spq_pkg::CMD_ADD) && prio_ok && !is_full)
      |=> (occ_r == $past(occ_r) + OCC_W'(1)) && out_valid
          && (out_status == spq_pkg::STS_ADDED))
    else $error("Accepted add did not insert an entry.");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd == spq_pkg::CMD_REMOVE) && !is_empty)
      |=> (occ_r == $past(occ_r) - OCC_W'(1)))
    else $error("Accepted remove did not pop an entry.");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue. A scoreboard keeps its
// own sorted copy of the queue, predicts every result of each accepted
// request and checks the results in order. Directed requests cover empty,
// full, bad priority and equal priority cases. Random phases with sender
// gaps, receiver stalls and one long receiver hold-off follow.
// ----------------------------------------------------------------------------

class spq_scoreboard;
  typedef struct {
    spq_pkg::status_t             status;
    logic [spq_pkg::OUT_ID_W-1:0] id;
    logic [spq_pkg::PRIO_W-1:0]   prio;
    logic                         last;
  } result_t;

  logic [spq_pkg::PRIO_W-1:0]      min_prio = spq_pkg::MIN_PRIO_RST;
  logic [spq_pkg::PRIO_W-1:0]      max_prio = spq_pkg::MAX_PRIO_RST;
  logic [spq_pkg::ID_BITS_DEF-1:0] slot_id [spq_pkg::CAPACITY_DEF];
  logic [spq_pkg::PRIO_W-1:0]      slot_prio [spq_pkg::CAPACITY_DEF];
  int                              occupancy = 0;
  logic [spq_pkg::ID_BITS_DEF-1:0] next_id = 1;
  result_t                         expected_results[$];
  int                              failures = 0;

  function void write_register(spq_pkg::cfg_reg_t idx, logic [spq_pkg::PRIO_W-1:0] value);
    if (idx == spq_pkg::REG_MIN_PRIO) min_prio = value;
    else max_prio = value;
  endfunction

  function void push(spq_pkg::status_t status, logic [spq_pkg::OUT_ID_W-1:0] id,
                     logic [spq_pkg::PRIO_W-1:0] prio, logic last);
    result_t r;
    r.status = status;
    r.id = id;
    r.prio = prio;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function void note_request(spq_pkg::cmd_t cmd, logic [spq_pkg::PRIO_W-1:0] prio);
    int pos;
    case (cmd)
      spq_pkg::CMD_ADD: begin
        if (prio < min_prio || prio > max_prio) begin
          push(spq_pkg::STS_BAD_PRIO, '0, prio, 1'b1);
        end else if (occupancy >= spq_pkg::CAPACITY_DEF) begin
          push(spq_pkg::STS_FULL, '0, prio, 1'b1);
        end else begin
          pos = 0;
          while (pos < occupancy && slot_prio[pos] > prio) pos++;
          for (int i = occupancy; i > pos; i--) begin
            slot_id[i] = slot_id[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_id[pos] = next_id;
          slot_prio[pos] = prio;
          occupancy++;
          push(spq_pkg::STS_ADDED, next_id, prio, 1'b1);
          next_id = next_id + 1'b1;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (occupancy == 0) begin
          push(spq_pkg::STS_EMPTY, '0, '0, 1'b1);
        end else begin
          push(spq_pkg::STS_REMOVED, slot_id[0], slot_prio[0], 1'b1);
          for (int i = 1; i < occupancy; i++) begin
            slot_id[i-1] = slot_id[i];
            slot_prio[i-1] = slot_prio[i];
          end
          occupancy--;
        end
      end
      spq_pkg::CMD_DISPLAY: begin
        if (occupancy == 0) begin
          push(spq_pkg::STS_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < occupancy && i < spq_pkg::MAX_RESULTS; i++)
            push(spq_pkg::STS_LISTED, slot_id[i], slot_prio[i],
                 (i + 1 == occupancy || i + 1 == spq_pkg::MAX_RESULTS));
        end
      end
      default: begin
        occupancy = 0;
        push(spq_pkg::STS_CLEARED, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function void report(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function void check_result(logic [spq_pkg::STATUS_W-1:0] status,
                             logic [spq_pkg::OUT_ID_W-1:0] id,
                             logic [spq_pkg::PRIO_W-1:0] prio, logic last);
    result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result: status %0d id %0d priority %0d last %0b",
                       status, id, prio, last));
      return;
    end
    want = expected_results.pop_front();
    if (status !== want.status || id !== want.id || prio !== want.prio || last !== want.last)
      report($sformatf({"result mismatch: expected status %0d id %0d priority %0d last %0b,",
                        " got status %0d id %0d priority %0d last %0b"},
                       want.status, want.id, want.prio, want.last, status, id, prio, last));
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [spq_pkg::CMD_W-1:0]      in_cmd = '0;
  logic [spq_pkg::PRIO_W-1:0]     in_priority_req = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [spq_pkg::STATUS_W-1:0]   out_status;
  logic [spq_pkg::OUT_ID_W-1:0]   out_entry_id;
  logic [spq_pkg::PRIO_W-1:0]     out_entry_priority;
  logic                           out_last;

  spq_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  sorted_priority_queue dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_entry_id       (out_entry_id),
    .out_entry_priority (out_entry_priority),
    .out_last           (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_entry_id, out_entry_priority, out_last);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(spq_pkg::cmd_t cmd, logic [spq_pkg::PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_priority_req <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(cmd, prio);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(logic [spq_pkg::PRIO_W-1:0] lo, logic [spq_pkg::PRIO_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= spq_pkg::REG_MIN_PRIO;
    cfg_wdata <= lo;
    @(posedge clk);
    sb.write_register(spq_pkg::REG_MIN_PRIO, lo);
    cfg_index <= spq_pkg::REG_MAX_PRIO;
    cfg_wdata <= hi;
    @(posedge clk);
    sb.write_register(spq_pkg::REG_MAX_PRIO, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [spq_pkg::PRIO_W-1:0] rand_prio();
    return spq_pkg::PRIO_W'($urandom_range(15));
  endfunction

  task automatic random_requests(int count, int add_w, int remove_w, int display_w);
    spq_pkg::cmd_t              cmd;
    logic [spq_pkg::PRIO_W-1:0] prio;
    int                         roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < add_w) cmd = spq_pkg::CMD_ADD;
      else if (roll < add_w + remove_w) cmd = spq_pkg::CMD_REMOVE;
      else if (roll < add_w + remove_w + display_w) cmd = spq_pkg::CMD_DISPLAY;
      else cmd = spq_pkg::CMD_CLEAR;
      prio = rand_prio();
      if (cmd == spq_pkg::CMD_ADD && sb.min_prio <= sb.max_prio && $urandom_range(9) < 8)
        prio = spq_pkg::PRIO_W'($urandom_range(sb.max_prio, sb.min_prio));
      send_request(cmd, prio);
    end
  endtask

  initial begin
    logic [spq_pkg::PRIO_W-1:0] lo;
    logic [spq_pkg::PRIO_W-1:0] hi;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default limits: empty queue, out of range adds, equal priorities.
    send_request(spq_pkg::CMD_REMOVE, rand_prio());
    send_request(spq_pkg::CMD_DISPLAY, rand_prio());
    send_request(spq_pkg::CMD_ADD, 4'd0);
    send_request(spq_pkg::CMD_ADD, 4'd11);
    send_request(spq_pkg::CMD_ADD, 4'd1);
    send_request(spq_pkg::CMD_ADD, 4'd10);
    send_request(spq_pkg::CMD_ADD, 4'd5);
    send_request(spq_pkg::CMD_ADD, 4'd5);
    send_request(spq_pkg::CMD_DISPLAY, rand_prio());
    send_request(spq_pkg::CMD_REMOVE, rand_prio());
    send_request(spq_pkg::CMD_CLEAR, rand_prio());
    send_request(spq_pkg::CMD_DISPLAY, rand_prio());
    wait_idle();

    // Full range, fill the queue past its capacity and list all of it.
    set_limits(4'd0, 4'd15);
    send_request(spq_pkg::CMD_ADD, 4'd0);
    send_request(spq_pkg::CMD_ADD, 4'd15);
    for (int k = 2; k < spq_pkg::CAPACITY_DEF; k++) send_request(spq_pkg::CMD_ADD, rand_prio());
    send_request(spq_pkg::CMD_ADD, 4'd9);
    send_request(spq_pkg::CMD_DISPLAY, rand_prio());
    send_request(spq_pkg::CMD_REMOVE, rand_prio());
    send_request(spq_pkg::CMD_CLEAR, rand_prio());
    wait_idle();

    // Crossed limits reject every add; a single-value window accepts one priority.
    set_limits(4'd15, 4'd0);
    send_request(spq_pkg::CMD_ADD, 4'd7);
    wait_idle();
    set_limits(4'd15, 4'd15);
    send_request(spq_pkg::CMD_ADD, 4'd15);
    send_request(spq_pkg::CMD_ADD, 4'd14);
    wait_idle();

    // No idling, with one long receiver hold-off that backs up the input.
    set_limits(4'd1, 4'd10);
    hold_token++;
    random_requests(125, 55, 25, 12);
    wait_idle();

    send_idle_pct = 59;
    set_limits(4'd0, 4'd15);
    random_requests(125, 60, 20, 15);
    wait_idle();

    send_idle_pct = 0;
    stall_pct = 59;
    lo = rand_prio();
    hi = spq_pkg::PRIO_W'($urandom_range(15, lo));
    set_limits(lo, hi);
    random_requests(125, 50, 30, 15);
    wait_idle();

    send_idle_pct = 21;
    stall_pct = 21;
    set_limits(4'd0, 4'd2);
    random_requests(125, 65, 20, 10);
    wait_idle();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
